>>> rtl/hss_pkg.sv
// Shared types, constants and register codes of the heat stencil step block.
`default_nettype none

package hss_pkg;

	localparam int DATA_WIDTH       = 32;
	localparam int FRAC_BITS        = 24;
	localparam int GRID_SIZE_WIDTH  = 11;
	localparam int CFG_INDEX_WIDTH  = 2;
	localparam int MIN_GRID         = 3;
	localparam int MAX_GRID_DEFAULT = 1024;

	localparam int GRID_SIZE_RST = 1024;
	localparam logic signed [DATA_WIDTH-1:0] CENTRE_WEIGHT_RST    = 32'sd8388608;
	localparam logic signed [DATA_WIDTH-1:0] NEIGHBOUR_WEIGHT_RST = 32'sd2097152;
	localparam logic signed [DATA_WIDTH-1:0] TIME_STEP_RST        = 32'sd16777;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_GRID_SIZE,
		REG_CENTRE_WEIGHT,
		REG_NEIGHBOUR_WEIGHT,
		REG_TIME_STEP
	} cfg_reg_t;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		data_t centre_weight;
		data_t neighbour_weight;
		data_t time_step;
	} weights_t;

	// Stencil window of one item: centre and neighbours of the point one row behind
	typedef struct packed {
		data_t centre;
		data_t left;
		data_t right;
		data_t up;
		data_t down;
		data_t source;
		logic  has_first;
		logic  has_second;
		logic  interior;
		logic  last_col;
	} window_t;

	// Up to two results of one item
	typedef struct packed {
		data_t first_value;
		data_t second_value;
		logic  has_first;
		logic  has_second;
		logic  last_col;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/heat_stencil_step.sv
// Top level of the heat stencil step block: configuration, window, arithmetic, result output.
`default_nettype none

// One explicit time step of the 2D heat equation on a square grid of grid_size points
// (clamped to 3..MAX_GRID). Old values enter in raster order, one item per cycle while
// in_ready is high; the result for a point leaves one row later, so the first row gives
// no result and each item of the last row gives two (the stencil result for the row
// above, then its own boundary value). Interior points get centre_weight*centre +
// neighbour_weight*(sum of four neighbours) + time_step*source_value in signed Q8.24,
// rounded half up and saturated; boundary points pass unchanged. An item passes the
// window register s1 and the arithmetic registers s2, s3 and s4 before out_valid rises.
// On the last row the single output port gives two results per item, so there each item
// holds the pipeline until its second result is taken. Writing grid_size restarts the
// raster at the first point; the row buffers need no clearing.
module heat_stencil_step #(
	parameter int MAX_GRID = hss_pkg::MAX_GRID_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [hss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [hss_pkg::DATA_WIDTH-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [hss_pkg::DATA_WIDTH-1:0] old_value,
	input  wire logic signed [hss_pkg::DATA_WIDTH-1:0] source_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [hss_pkg::DATA_WIDTH-1:0]    new_value,
	output logic                                     last_of_run,
	output logic                                     end_of_grid
);
	import hss_pkg::*;

	localparam int AW = $clog2(MAX_GRID);

	weights_t      weights;
	logic [AW-1:0] last_idx;
	logic          restart;
	logic          win_valid;
	logic          win_take;
	window_t       win;
	logic          res_valid;
	logic          res_done;
	result_t       res;
	logic          sel_q;
	logic          show_second;

	hss_cfg #(
		.MAX_GRID (MAX_GRID)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.weights   (weights),
		.last_idx  (last_idx),
		.restart   (restart)
	);

	hss_window #(
		.MAX_GRID (MAX_GRID)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.old_value    (old_value),
		.source_value (source_value),
		.last_idx     (last_idx),
		.restart      (restart),
		.win_valid    (win_valid),
		.win_take     (win_take),
		.win          (win)
	);

	hss_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win_take  (win_take),
		.win       (win),
		.weights   (weights),
		.res_valid (res_valid),
		.res_done  (res_done),
		.res       (res)
	);

	// Show the first result, then the second; release the item after its last one
	assign show_second = sel_q || !res.has_first;
	assign res_done    = res_valid && out_ready && (show_second || !res.has_second);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (res_valid && out_ready) begin
			sel_q <= !res_done;
		end
	end

	assign out_valid   = res_valid;
	assign new_value   = show_second ? res.second_value : res.first_value;
	assign last_of_run = show_second || !res.has_second;
	assign end_of_grid = show_second && res.last_col;

endmodule

`default_nettype wire

>>> rtl/hss_cfg.sv
// Configuration registers and effective grid size of the heat stencil step block.
`default_nettype none

module hss_cfg #(
	parameter int MAX_GRID = hss_pkg::MAX_GRID_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [hss_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [hss_pkg::DATA_WIDTH-1:0]      cfg_data,
	output hss_pkg::weights_t                        weights,
	output logic [$clog2(MAX_GRID)-1:0]              last_idx,
	output logic                                     restart
);
	import hss_pkg::*;

	localparam int AW  = $clog2(MAX_GRID);
	localparam int MW  = $clog2(MAX_GRID + 1);
	localparam int CW  = (MW > GRID_SIZE_WIDTH) ? MW : GRID_SIZE_WIDTH;
	localparam logic [AW-1:0] RST_LAST =
		AW'(((GRID_SIZE_RST > MAX_GRID) ? MAX_GRID : GRID_SIZE_RST) - 1);

	weights_t      weights_q;
	logic [AW-1:0] last_idx_q;
	logic [CW-1:0] size_ext;
	logic [AW-1:0] last_d;

	// Clamp the written size to the supported range and keep its last index
	always_comb begin
		size_ext = CW'(cfg_data[GRID_SIZE_WIDTH-1:0]);
		if (size_ext < CW'(MIN_GRID)) begin
			last_d = AW'(MIN_GRID - 1);
		end else if (size_ext > CW'(MAX_GRID)) begin
			last_d = AW'(MAX_GRID - 1);
		end else begin
			last_d = AW'(size_ext - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q.centre_weight    <= CENTRE_WEIGHT_RST;
			weights_q.neighbour_weight <= NEIGHBOUR_WEIGHT_RST;
			weights_q.time_step        <= TIME_STEP_RST;
			last_idx_q                 <= RST_LAST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_SIZE:        last_idx_q                 <= last_d;
				REG_CENTRE_WEIGHT:    weights_q.centre_weight    <= cfg_data;
				REG_NEIGHBOUR_WEIGHT: weights_q.neighbour_weight <= cfg_data;
				REG_TIME_STEP:        weights_q.time_step        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign weights  = weights_q;
	assign last_idx = last_idx_q;
	assign restart  = cfg_write && (cfg_reg_t'(cfg_index) == REG_GRID_SIZE);

endmodule

`default_nettype wire

>>> rtl/hss_window.sv
// Raster counters and two row buffers that assemble the five-point window.
`default_nettype none

module hss_window #(
	parameter int MAX_GRID = hss_pkg::MAX_GRID_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire hss_pkg::data_t                 old_value,
	input  wire hss_pkg::data_t                 source_value,
	input  wire logic [$clog2(MAX_GRID)-1:0]    last_idx,
	input  wire logic                           restart,
	output logic                                win_valid,
	input  wire logic                           win_take,
	output hss_pkg::window_t                    win
);
	import hss_pkg::*;

	localparam int AW = $clog2(MAX_GRID);

	data_t prev_mem  [MAX_GRID];
	data_t sprev_mem [MAX_GRID];

	logic [AW-1:0] col_q;
	logic [AW-1:0] row_q;
	logic [AW-1:0] col_next;
	logic [AW-1:0] col_s1;
	logic          valid_s1;
	logic          sprev_wr_q;
	logic          accept;

	data_t centre_s1;
	data_t left_s1;
	data_t right_s1;
	data_t up_s1;
	data_t down_s1;
	data_t source_s1;
	logic  has_first_s1;
	logic  has_second_s1;
	logic  interior_s1;
	logic  last_col_s1;

	assign in_ready = !valid_s1 || win_take;
	assign accept   = in_valid && in_ready;
	assign col_next = (col_q == last_idx) ? '0 : col_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
			sprev_wr_q <= 1'b0;
		end else begin
			sprev_wr_q <= accept;
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				col_q <= col_next;
				if (col_q == last_idx) begin
					row_q <= (row_q == last_idx) ? '0 : row_q + AW'(1);
				end
			end
		end
	end

	// Row buffers: read the window on acceptance, shift the old row down in the following cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_mem[col_q] <= old_value;
			centre_s1       <= prev_mem[col_q];
			right_s1        <= prev_mem[col_next];
			up_s1           <= sprev_mem[col_q];
			left_s1         <= centre_s1;
			down_s1         <= old_value;
			source_s1       <= source_value;
			col_s1          <= col_q;
			has_first_s1    <= (row_q != '0);
			has_second_s1   <= (row_q == last_idx);
			interior_s1     <= (row_q > AW'(1)) && (col_q != '0) && (col_q != last_idx);
			last_col_s1     <= (col_q == last_idx);
		end
		if (sprev_wr_q) begin
			sprev_mem[col_s1] <= centre_s1;
		end
	end

	assign win_valid      = valid_s1;
	assign win.centre     = centre_s1;
	assign win.left       = left_s1;
	assign win.right      = right_s1;
	assign win.up         = up_s1;
	assign win.down       = down_s1;
	assign win.source     = source_s1;
	assign win.has_first  = has_first_s1;
	assign win.has_second = has_second_s1;
	assign win.interior   = interior_s1;
	assign win.last_col   = last_col_s1;

endmodule

`default_nettype wire

>>> rtl/hss_arith.sv
// Stencil arithmetic: neighbour sum, weighted products, rounding and saturation.
`default_nettype none

module hss_arith (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                win_valid,
	output logic                     win_take,
	input  wire hss_pkg::window_t    win,
	input  wire hss_pkg::weights_t   weights,
	output logic                     res_valid,
	input  wire logic                res_done,
	output hss_pkg::result_t         res
);
	import hss_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int NW = DW + 2;
	localparam int PW = 2 * DW;
	localparam int QW = NW + DW;
	localparam int SW = QW + 2;
	localparam int HW = SW - FRAC_BITS;
	localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW - 1){1'b1}}};
	localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW - 1){1'b0}}};

	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic en2;
	logic en3;
	logic en4;

	logic signed [NW-1:0] nsum_d;
	logic signed [NW-1:0] nsum_s2;
	data_t                centre_s2;
	data_t                down_s2;
	data_t                source_s2;
	logic                 has_first_s2;
	logic                 has_second_s2;
	logic                 interior_s2;
	logic                 last_col_s2;

	logic signed [PW-1:0] prod_c_s3;
	logic signed [QW-1:0] prod_n_s3;
	logic signed [PW-1:0] prod_s_s3;
	data_t                centre_s3;
	data_t                down_s3;
	logic                 has_first_s3;
	logic                 has_second_s3;
	logic                 interior_s3;
	logic                 last_col_s3;

	logic signed [SW-1:0] sum_d;
	logic [HW-1:0]        hi_d;
	logic [HW-DW:0]       top_d;
	logic [DW-1:0]        sat_d;

	result_t res_s4;

	assign en4      = !valid_s4 || res_done;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign win_take = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			// drop items of the first row: they give no result
			if (en2) valid_s2 <= win_valid && (win.has_first || win.has_second);
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	assign nsum_d = NW'(win.left) + NW'(win.right) + NW'(win.up) + NW'(win.down);

	// Exact sum of the products, rounded half up at the binary point and saturated
	always_comb begin
		sum_d = SW'(prod_c_s3) + SW'(prod_n_s3) + SW'(prod_s_s3) + ROUND_HALF;
		hi_d  = sum_d[SW-1:FRAC_BITS];
		top_d = hi_d[HW-1:DW-1];
		if ((&top_d) || !(|top_d)) begin
			sat_d = hi_d[DW-1:0];
		end else begin
			sat_d = sum_d[SW-1] ? SAT_MIN : SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			nsum_s2       <= nsum_d;
			centre_s2     <= win.centre;
			down_s2       <= win.down;
			source_s2     <= win.source;
			has_first_s2  <= win.has_first;
			has_second_s2 <= win.has_second;
			interior_s2   <= win.interior;
			last_col_s2   <= win.last_col;
		end
		if (en3) begin
			prod_c_s3     <= PW'(centre_s2) * PW'(weights.centre_weight);
			prod_n_s3     <= QW'(nsum_s2) * QW'(weights.neighbour_weight);
			prod_s_s3     <= PW'(source_s2) * PW'(weights.time_step);
			centre_s3     <= centre_s2;
			down_s3       <= down_s2;
			has_first_s3  <= has_first_s2;
			has_second_s3 <= has_second_s2;
			interior_s3   <= interior_s2;
			last_col_s3   <= last_col_s2;
		end
		if (en4) begin
			res_s4.first_value  <= interior_s3 ? data_t'(sat_d) : centre_s3;
			res_s4.second_value <= down_s3;
			res_s4.has_first    <= has_first_s3;
			res_s4.has_second   <= has_second_s3;
			res_s4.last_col     <= last_col_s3;
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule

`default_nettype wire

>>> tb/heat_stencil_step_tb.sv
// Self-checking testbench for heat_stencil_step: stencil prediction, directed plan, random grids.
module heat_stencil_step_tb;
	import hss_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 10;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_PHASES = 16;
	localparam int PLAN_ROWS     = 34;
	localparam int WIDE_ITEMS    = 32;

	localparam data_t MAX_Q       = 32'sh7FFF_FFFF;
	localparam data_t MIN_Q       = 32'sh8000_0000;
	localparam data_t HALF_Q      = 32'sh0080_0000;
	localparam data_t NOISE_Q     = 32'sh5A5A_5A5A;
	localparam data_t VALUE_SPAN  = 32'sh0800_0000;
	localparam data_t WEIGHT_SPAN = 32'sh0100_0000;

	localparam logic [3:0] ALL_REGS    = 4'b1111;
	localparam logic [3:0] WEIGHT_REGS = ALL_REGS & ~(4'(1) << REG_GRID_SIZE);

	typedef enum logic {PLAN_WRITE, PLAN_ITEM} plan_kind_t;
	typedef enum logic [1:0] {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

	typedef struct packed {
		plan_kind_t kind;
		cfg_reg_t   target;
		data_t      a;
		data_t      b;
		logic       typed;
		data_t      want0;
		data_t      want1;
	} plan_row_t;

	typedef struct packed {
		data_t value;
		logic  last;
		logic  eog;
	} point_result_t;

	// Register writes and old/source values; typed rows carry the values of their results
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{PLAN_WRITE, REG_GRID_SIZE, 32'sd3, '0, 1'b0, '0, '0},
		// first row only fills the buffers; sources there are ignored
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0100_0000, NOISE_Q, 1'b0, '0, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0200_0000, NOISE_Q, 1'b0, '0, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0300_0000, NOISE_Q, 1'b0, '0, '0},
		// second row hands back the first one unchanged
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0400_0000, NOISE_Q, 1'b1, 32'sh0100_0000, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0500_0000, NOISE_Q, 1'b1, 32'sh0200_0000, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0600_0000, NOISE_Q, 1'b1, 32'sh0300_0000, '0},
		// last row: edge of the row above, then the point itself; the middle is a rounding tie
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0700_0000, NOISE_Q, 1'b1,
			32'sh0400_0000, 32'sh0700_0000},
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0800_0000, HALF_Q, 1'b0, '0, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, 32'sh0900_0000, NOISE_Q, 1'b1,
			32'sh0600_0000, 32'sh0900_0000},
		// everything at the top of the range: the interior saturates high
		'{PLAN_WRITE, REG_CENTRE_WEIGHT, MAX_Q, '0, 1'b0, '0, '0},
		'{PLAN_WRITE, REG_NEIGHBOUR_WEIGHT, MAX_Q, '0, 1'b0, '0, '0},
		'{PLAN_WRITE, REG_TIME_STEP, MAX_Q, '0, 1'b0, '0, '0},
		'{PLAN_WRITE, REG_GRID_SIZE, 32'sd3, '0, 1'b0, '0, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MAX_Q, MAX_Q, 1'b1, MAX_Q, MAX_Q},
		// most negative values and step; size zero clamps to three; interior saturates low
		'{PLAN_WRITE, REG_TIME_STEP, MIN_Q, '0, 1'b0, '0, '0},
		'{PLAN_WRITE, REG_GRID_SIZE, 32'sd0, '0, 1'b0, '0, '0},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q},
		'{PLAN_ITEM, REG_GRID_SIZE, MIN_Q, MIN_Q, 1'b1, MIN_Q, MIN_Q}
	};

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       cfg_write    = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
	logic [DATA_WIDTH-1:0]      cfg_data     = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	data_t                      old_value    = '0;
	data_t                      source_value = '0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	data_t                      new_value;
	logic                       last_of_run;
	logic                       end_of_grid;

	// predictor copy of the registers and row buffers
	logic [GRID_SIZE_WIDTH-1:0] p_grid     = GRID_SIZE_WIDTH'(GRID_SIZE_RST);
	data_t                      p_centre_w = CENTRE_WEIGHT_RST;
	data_t                      p_neigh_w  = NEIGHBOUR_WEIGHT_RST;
	data_t                      p_step_w   = TIME_STEP_RST;
	data_t                      centre_line [MAX_GRID_DEFAULT];
	data_t                      upper_line [MAX_GRID_DEFAULT];
	int                         col_pos    = 0;
	int                         row_pos    = 0;

	point_result_t pending_points [$];
	point_result_t due;
	int            idle_pct        = 0;
	int            stall_pct       = 0;
	int            hold_left       = 0;
	int            items_taken     = 0;
	int            results_checked = 0;
	int            settings_done   = 0;
	int            failures        = 0;

	heat_stencil_step u_top (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic data_t heat_update(input data_t centre, left, right, up, down, src);
		logic signed [69:0] acc;
		logic signed [69:0] wc;
		logic signed [69:0] wn;
		logic signed [69:0] ws;
		wc = p_centre_w;
		wn = p_neigh_w;
		ws = p_step_w;
		acc = wc * centre + wn * left + wn * right + wn * up + wn * down + ws * src;
		// round half up at the binary point, then clip
		acc = (acc + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (acc > MAX_Q)
			return MAX_Q;
		if (acc < MIN_Q)
			return MIN_Q;
		return acc[DATA_WIDTH-1:0];
	endfunction

	function automatic void advance_grid(input data_t cur, src, input logic typed,
			input data_t want0, want1);
		int            n;
		int            made;
		data_t         val;
		point_result_t res [2];
		n = (p_grid < MIN_GRID) ? MIN_GRID :
			(p_grid > MAX_GRID_DEFAULT) ? MAX_GRID_DEFAULT : int'(p_grid);
		made = 0;
		if (row_pos >= 1) begin
			if (row_pos == 1 || col_pos == 0 || col_pos == n - 1)
				val = centre_line[col_pos];
			else
				val = heat_update(centre_line[col_pos], upper_line[col_pos - 1],
					centre_line[col_pos + 1], upper_line[col_pos], cur, src);
			res[0] = '{typed ? want0 : val, 1'b0, 1'b0};
			made = 1;
		end
		upper_line[col_pos] = centre_line[col_pos];
		centre_line[col_pos] = cur;
		// bottom row is boundary: it leaves as it came, right after the row above
		if (row_pos >= n - 1) begin
			res[made] = '{typed ? want1 : cur, 1'b0, col_pos == n - 1};
			made++;
		end
		if (made > 0)
			res[made - 1].last = 1'b1;
		for (int i = 0; i < made; i++)
			pending_points.push_back(res[i]);
		if (col_pos >= n - 1) begin
			col_pos = 0;
			row_pos = (row_pos >= n - 1) ? 0 : row_pos + 1;
		end else
			col_pos++;
	endfunction

	function automatic data_t pick_q(input data_t span);
		case ($urandom_range(15))
			0: return MAX_Q;
			1: return MIN_Q;
			2: return '0;
			3: return data_t'(1);
			4: return data_t'(-1);
			5, 6: return data_t'($urandom);
			default: return data_t'($urandom_range(2 * span)) - span;
		endcase
	endfunction

	function automatic void set_flow(input flow_t f);
		case (f)
			FLOW_FREE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			FLOW_SENDER_IDLE: begin
				idle_pct = 85;
				stall_pct = 0;
			end
			FLOW_RECEIVER_STALL: begin
				idle_pct = 0;
				stall_pct = 85;
			end
			default: begin
				idle_pct = 6;
				stall_pct = 6;
			end
		endcase
	endfunction

	task automatic send_point(input data_t cur, src, input logic typed, input data_t want0, want1);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		old_value <= cur;
		source_value <= src;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_grid(cur, src, typed, want0, want1);
		items_taken++;
	endtask

	// hold the input until every result is back, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [3:0] sel, input data_t grid, cw, nw, ts);
		cfg_reg_t target;
		data_t    word;
		for (int i = 0; i < 4; i++) begin
			target = cfg_reg_t'(i);
			if (sel[i]) begin
				case (target)
					REG_GRID_SIZE: begin
						word = grid;
						p_grid = grid[GRID_SIZE_WIDTH-1:0];
						col_pos = 0;
						row_pos = 0;
					end
					REG_CENTRE_WEIGHT: begin
						word = cw;
						p_centre_w = cw;
					end
					REG_NEIGHBOUR_WEIGHT: begin
						word = nw;
						p_neigh_w = nw;
					end
					default: begin
						word = ts;
						p_step_w = ts;
					end
				endcase
				cfg_write <= 1'b1;
				cfg_index <= target;
				cfg_data <= word;
				@(posedge clk);
			end
		end
		cfg_write <= 1'b0;
		settings_done++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$error("new_value %h arrived with nothing pending", new_value);
				failures++;
			end else begin
				due = pending_points.pop_front();
				results_checked++;
				if (new_value !== due.value) begin
					$error("new_value: expected %h, got %h", due.value, new_value);
					failures++;
				end
				if (last_of_run !== due.last) begin
					$error("last_of_run: expected %b, got %b", due.last, last_of_run);
					failures++;
				end
				if (end_of_grid !== due.eog) begin
					$error("end_of_grid: expected %b, got %b", due.eog, end_of_grid);
					failures++;
				end
			end
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timed out after %0d cycles with %0d results pending",
			CYCLE_LIMIT, pending_points.size());
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		plan_row_t row;
		int        count;
		int        g;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_flow(FLOW_BOTH);
		for (int i = 0; i < PLAN_ROWS; i++) begin
			row = PLAN[i];
			if (row.kind == PLAN_WRITE) begin
				drain();
				write_regs(4'(1) << row.target, row.a, row.a, row.a, row.a);
			end else
				send_point(row.a, row.b, row.typed, row.want0, row.want1);
		end

		// widest grids, the largest size and then the widest field value that clamps to it:
		// the first row only fills the buffers, so nothing may come out
		set_flow(FLOW_FREE);
		drain();
		write_regs(ALL_REGS, data_t'(MAX_GRID_DEFAULT), pick_q(WEIGHT_SPAN),
			pick_q(WEIGHT_SPAN), pick_q(WEIGHT_SPAN));
		repeat (WIDE_ITEMS)
			send_point(pick_q(VALUE_SPAN), pick_q(VALUE_SPAN), 1'b0, '0, '0);
		drain();
		write_regs(4'(1) << REG_GRID_SIZE, data_t'((1 << GRID_SIZE_WIDTH) - 1), '0, '0, '0);
		repeat (WIDE_ITEMS)
			send_point(pick_q(VALUE_SPAN), pick_q(VALUE_SPAN), 1'b0, '0, '0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_flow(flow_t'(phase % 4));
			drain();
			case ($urandom_range(7))
				0: g = $urandom_range(MIN_GRID - 1);
				1: g = MIN_GRID;
				default: g = $urandom_range(MIN_GRID, 7);
			endcase
			write_regs(ALL_REGS, data_t'(g), pick_q(WEIGHT_SPAN), pick_q(WEIGHT_SPAN),
				pick_q(WEIGHT_SPAN));
			// output blocked for a long stretch while items keep coming
			if (phase == 4)
				hold_left = LONG_HOLD;
			count = $urandom_range(36, 52);
			for (int k = 0; k < count; k++) begin
				send_point(pick_q(VALUE_SPAN), pick_q(VALUE_SPAN), 1'b0, '0, '0);
				if (k == count / 2) begin
					if (phase % 5 == 2)
						drain();
					else if (phase % 5 == 3) begin
						// new weights mid-grid: raster position carries on
						drain();
						write_regs(WEIGHT_REGS, '0, pick_q(WEIGHT_SPAN), pick_q(WEIGHT_SPAN),
							pick_q(WEIGHT_SPAN));
					end
				end
			end
		end

		drain();
		$display("checked %0d results from %0d items across %0d register settings",
			results_checked, items_taken, settings_done);
		$display("grid sizes from 0 to 2047, saturating weights, stalls and long back-pressure");
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
